### src/yaw_pitch_fly_camera_assert.svh
// assertion macros for the fly camera
`ifndef YAW_PITCH_FLY_CAMERA_ASSERT_SVH
`define YAW_PITCH_FLY_CAMERA_ASSERT_SVH
// property that holds while out of reset
`define YPFC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked in reset as well
`define YPFC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### src/ypfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypfc_pkg
// types and constants shared by the fly camera block
// ----------------------------------------------------------------------------
package ypfc_pkg;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_LOOK  = 2'd1,
    OP_ZOOM  = 2'd2,
    OP_PLACE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_FORWARD  = 2'd0,
    DIR_BACKWARD = 2'd1,
    DIR_LEFT     = 2'd2,
    DIR_RIGHT    = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    REG_MOVE_SPEED  = 3'd0,
    REG_LOOK_SENS   = 3'd1,
    REG_UP_X        = 3'd2,
    REG_UP_Y        = 3'd3,
    REG_UP_Z        = 3'd4,
    REG_START_YAW   = 3'd5,
    REG_START_PITCH = 3'd6
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOVE,
    ST_LOOK,
    ST_CORDIC_SETUP,
    ST_CORDIC_RUN,
    ST_CORDIC_DONE,
    ST_FRONT,
    ST_CROSS,
    ST_LEN,
    ST_SQRT,
    ST_DIV,
    ST_UP,
    ST_DONE
  } state_e;

  localparam int ANGLE_HALF  = 23040;
  localparam int ANGLE_FULL  = 46080;
  localparam int PITCH_LIMIT = 11392;
  localparam int ZOOM_MIN    = 128;
  localparam int ZOOM_MAX    = 5760;
  localparam int ONE_Q14     = 16384;
  localparam int DEG_TO_RAD  = 146409;
  localparam int CORDIC_X0   = 652032874;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h3243F6A8;  5'd1: r = 32'h1DAC6705;
        5'd2: r = 32'h0FADBAFC;  5'd3: r = 32'h07F56EA6;
        5'd4: r = 32'h03FEAB76;  5'd5: r = 32'h01FFD55B;
        5'd6: r = 32'h00FFFAAA;  5'd7: r = 32'h007FFF55;
        5'd8: r = 32'h003FFFEA;  5'd9: r = 32'h001FFFFD;
        5'd10: r = 32'h000FFFFF; 5'd11: r = 32'h0007FFFF;
        5'd12: r = 32'h0003FFFF; 5'd13: r = 32'h0001FFFF;
        5'd14: r = 32'h0000FFFF; 5'd15: r = 32'h00007FFF;
        5'd16: r = 32'h00003FFF; 5'd17: r = 32'h00001FFF;
        5'd18: r = 32'h00000FFF; 5'd19: r = 32'h000007FF;
        5'd20: r = 32'h000003FF; 5'd21: r = 32'h000001FF;
        5'd22: r = 32'h000000FF; 5'd23: r = 32'h0000007F;
        5'd24: r = 32'h0000003F; 5'd25: r = 32'h0000001F;
        5'd26: r = 32'h0000000F; 5'd27: r = 32'h00000008;
        5'd28: r = 32'h00000004; 5'd29: r = 32'h00000002;
        5'd30: r = 32'h00000001; default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

  // wrap a degree sum (within about +-8 turns) into -23040..23039
  // offset to non-negative, then compare-subtract 4, 2 and 1 turns
  function automatic logic signed [15:0] wrap_deg(input logic signed [20:0] v);
    logic signed [21:0] r;
    begin
      r = 22'(v) + 22'(ANGLE_HALF);
      if (r < 0) r = r + 22'(8 * ANGLE_FULL);
      if (r >= 22'(4 * ANGLE_FULL)) r = r - 22'(4 * ANGLE_FULL);
      if (r >= 22'(2 * ANGLE_FULL)) r = r - 22'(2 * ANGLE_FULL);
      if (r >= 22'(ANGLE_FULL)) r = r - 22'(ANGLE_FULL);
      r = r - 22'(ANGLE_HALF);
      return r[15:0];
    end
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [47:0] v);
    begin
      if (v > 48'sd16384) return 16'sd16384;
      else if (v < -48'sd16384) return -16'sd16384;
      else return v[15:0];
    end
  endfunction

endpackage

### src/yaw_pitch_fly_camera.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pitch_fly_camera
// first-person camera pose: position, yaw, pitch, zoom and basis vectors
// ----------------------------------------------------------------------------
// sequence: look and place run the cordic for yaw and pitch, then front, cross,
//   length, square root, divide and up; the divide is skipped when the cross product is zero
// throughput: one request at a time, the next taken the cycle after the result
//   leaves; the shared multiplier, the serial cordic, the bit-serial square
//   root and the serial divider set how long a request takes
// reset: pose, vectors and configuration registers return to their defaults at once
module yaw_pitch_fly_camera #(
  parameter int POSITION_WIDTH    = 32,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [1:0]         direction_i,
  input  logic [15:0]        delta_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic               pitch_clamp_i,
  input  logic signed [31:0] place_x_i,
  input  logic signed [31:0] place_y_i,
  input  logic signed [31:0] place_z_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic [12:0]        zoom_deg_o,
  output logic signed [15:0] yaw_deg_o,
  output logic signed [15:0] pitch_deg_o
);

  localparam int PW = POSITION_WIDTH;
  localparam int CIW = $clog2(CORDIC_ITERATIONS + 1);
  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  // configuration registers
  logic [15:0] speed_q, sens_q;
  logic signed [15:0] wup_q [3];
  logic signed [15:0] syaw_q;
  logic signed [14:0] spitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= 16'd640;
      sens_q   <= 16'd6554;
      wup_q[0] <= '0;
      wup_q[1] <= 16'sd16384;
      wup_q[2] <= '0;
      syaw_q   <= -16'sd11520;
      spitch_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ypfc_pkg::REG_MOVE_SPEED:  speed_q  <= cfg_data_i;
        ypfc_pkg::REG_LOOK_SENS:   sens_q   <= cfg_data_i;
        ypfc_pkg::REG_UP_X:        wup_q[0] <= cfg_data_i;
        ypfc_pkg::REG_UP_Y:        wup_q[1] <= cfg_data_i;
        ypfc_pkg::REG_UP_Z:        wup_q[2] <= cfg_data_i;
        ypfc_pkg::REG_START_YAW:   syaw_q   <= cfg_data_i;
        ypfc_pkg::REG_START_PITCH: spitch_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // state
  ypfc_pkg::state_e state_q, state_d;
  logic signed [PW-1:0] pos_q [3], pos_d [3];
  logic signed [15:0] yaw_q, yaw_d, pitch_q, pitch_d;
  logic [12:0] zoom_q, zoom_d;
  logic signed [15:0] fv_q [3], fv_d [3], rv_q [3], rv_d [3], uv_q [3], uv_d [3];

  // working registers
  logic [1:0]  dir_q, dir_d;
  logic [2:0]  k_q, k_d;                 // component / phase counter
  logic        ang_q, ang_d;             // 0 yaw, 1 pitch
  logic        neg_q, neg_d;
  logic [CIW-1:0] it_q, it_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [33:0] sy_q, sy_d, cyw_q, cyw_d, sp_q, sp_d, cp_q, cp_d;
  logic signed [63:0] acc_q, acc_d;      // general accumulator
  logic [31:0] vel_q, vel_d;             // speed * delta, unsigned
  logic signed [33:0] cr_q [3], cr_d [3];
  logic [63:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic out_valid_q, out_valid_d;

  // the shared multiplier; its product is registered into acc or into the result
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;
  assign mprod = ma * mb;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ypfc_pkg::ST_IDLE) || out_valid_q;

  logic signed [PW-1:0] place_sat [3];
  logic signed [31:0] place_in [3];
  assign place_in[0] = place_x_i;
  assign place_in[1] = place_y_i;
  assign place_in[2] = place_z_i;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (PW < 32 && 64'(place_in[i]) > 64'(PMAX)) begin
        place_sat[i] = PMAX;
      end else if (PW < 32 && 64'(place_in[i]) < 64'(PMIN)) begin
        place_sat[i] = PMIN;
      end else begin
        place_sat[i] = PW'(place_in[i]);
      end
    end
  end

  // indexed temporaries
  logic signed [15:0] step_vec;
  logic signed [63:0] rnd, step;
  logic signed [64:0] psum;
  logic signed [20:0] angle_sum;
  logic signed [33:0] shx, shy;
  logic signed [18:0] deg_w;
  logic signed [63:0] numer, absn;
  logic [63:0] trial;

  always_comb begin
    state_d = state_q;
    pos_d = pos_q; yaw_d = yaw_q; pitch_d = pitch_q; zoom_d = zoom_q;
    fv_d = fv_q; rv_d = rv_q; uv_d = uv_q;
    dir_d = dir_q; k_d = k_q; ang_d = ang_q;
    neg_d = neg_q; it_d = it_q; cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    sy_d = sy_q; cyw_d = cyw_q; sp_d = sp_q; cp_d = cp_q;
    acc_d = acc_q; vel_d = vel_q; cr_d = cr_q;
    rem_d = rem_q; root_d = root_q; bit_d = bit_q; cnt_d = cnt_q; quo_d = quo_q;
    out_valid_d = out_valid_q;
    ma = '0; mb = '0;
    step_vec = '0; rnd = '0; step = '0; psum = '0;
    angle_sum = '0; shx = '0; shy = '0; deg_w = '0; numer = '0; absn = '0;
    trial = '0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      ypfc_pkg::ST_IDLE: begin
        if (accept) begin
          dir_d = direction_i; k_d = '0;
          unique case (ypfc_pkg::op_e'(operation_i))
            ypfc_pkg::OP_MOVE: begin
              vel_d = 32'(speed_q) * 32'(delta_i);
              state_d = ypfc_pkg::ST_MOVE;
            end
            ypfc_pkg::OP_LOOK: begin
              // first phase: yaw offset
              ma = 34'(offset_x_i); mb = 34'(signed'({1'b0, sens_q}));
              acc_d = 64'(mprod);
              cy_d = 34'(offset_y_i);
              neg_d = pitch_clamp_i;
              state_d = ypfc_pkg::ST_LOOK;
            end
            ypfc_pkg::OP_ZOOM: begin
              psum = 65'(zoom_q) - 65'(offset_y_i) * 65'sd8;
              if (psum < 65'(ypfc_pkg::ZOOM_MIN)) zoom_d = 13'(ypfc_pkg::ZOOM_MIN);
              else if (psum > 65'(ypfc_pkg::ZOOM_MAX)) zoom_d = 13'(ypfc_pkg::ZOOM_MAX);
              else zoom_d = psum[12:0];
              state_d = ypfc_pkg::ST_DONE;
            end
            default: begin
              pos_d = place_sat;
              yaw_d = ypfc_pkg::wrap_deg(21'(syaw_q));
              pitch_d = ypfc_pkg::wrap_deg(21'(spitch_q));
              zoom_d = 13'(ypfc_pkg::ZOOM_MAX);
              ang_d = 1'b0;
              state_d = ypfc_pkg::ST_CORDIC_SETUP;
            end
          endcase
        end
      end

      ypfc_pkg::ST_MOVE: begin
        step_vec = (dir_q[1] == 1'b0) ? fv_q[k_q[1:0]] : rv_q[k_q[1:0]];
        ma = 34'(vel_q); mb = 34'(step_vec);
        rnd = 64'(mprod) + 64'sd2097152;
        step = rnd >>> 22;
        if (dir_q == ypfc_pkg::DIR_BACKWARD || dir_q == ypfc_pkg::DIR_LEFT) step = -step;
        psum = 65'(pos_q[k_q[1:0]]) + 65'(step);
        if (psum > 65'(PMAX)) pos_d[k_q[1:0]] = PMAX;
        else if (psum < 65'(PMIN)) pos_d[k_q[1:0]] = PMIN;
        else pos_d[k_q[1:0]] = psum[PW-1:0];
        k_d = k_q + 3'd1;
        if (k_q == 3'd2) state_d = ypfc_pkg::ST_DONE;
      end

      ypfc_pkg::ST_LOOK: begin
        rnd = (acc_q + 64'sd4096) >>> 13;
        if (k_q == 3'd0) begin
          yaw_d = ypfc_pkg::wrap_deg(21'(yaw_q) + 21'(rnd));
          ma = cy_q; mb = 34'(signed'({1'b0, sens_q}));
          acc_d = 64'(mprod);
          k_d = 3'd1;
        end else begin
          angle_sum = 21'(pitch_q) + 21'(rnd);
          if (neg_q) begin
            if (angle_sum > 21'(ypfc_pkg::PITCH_LIMIT)) pitch_d = 16'(ypfc_pkg::PITCH_LIMIT);
            else if (angle_sum < -21'(ypfc_pkg::PITCH_LIMIT))
              pitch_d = -16'(ypfc_pkg::PITCH_LIMIT);
            else pitch_d = angle_sum[15:0];
          end else begin
            pitch_d = ypfc_pkg::wrap_deg(angle_sum);
          end
          ang_d = 1'b0;
          state_d = ypfc_pkg::ST_CORDIC_SETUP;
        end
      end

      ypfc_pkg::ST_CORDIC_SETUP: begin
        deg_w = 19'(ang_q ? pitch_q : yaw_q);
        neg_d = 1'b0;
        if (deg_w > 19'(ypfc_pkg::ANGLE_HALF / 2)) begin
          deg_w = deg_w - 19'(ypfc_pkg::ANGLE_HALF); neg_d = 1'b1;
        end else if (deg_w < -19'(ypfc_pkg::ANGLE_HALF / 2)) begin
          deg_w = deg_w + 19'(ypfc_pkg::ANGLE_HALF); neg_d = 1'b1;
        end
        ma = 34'(deg_w); mb = 34'(ypfc_pkg::DEG_TO_RAD);
        cz_d = 34'(mprod);
        cx_d = 34'(ypfc_pkg::CORDIC_X0); cy_d = '0; it_d = '0;
        state_d = ypfc_pkg::ST_CORDIC_RUN;
      end

      ypfc_pkg::ST_CORDIC_RUN: begin
        shx = cx_q >>> it_q; shy = cy_q >>> it_q;
        if (cz_q >= 0) begin
          cx_d = cx_q - shy; cy_d = cy_q + shx;
          cz_d = cz_q - 34'(ypfc_pkg::atan_q30(5'(it_q)));
        end else begin
          cx_d = cx_q + shy; cy_d = cy_q - shx;
          cz_d = cz_q + 34'(ypfc_pkg::atan_q30(5'(it_q)));
        end
        it_d = it_q + CIW'(1);
        if (it_q == CIW'(CORDIC_ITERATIONS - 1)) state_d = ypfc_pkg::ST_CORDIC_DONE;
      end

      ypfc_pkg::ST_CORDIC_DONE: begin
        if (!ang_q) begin
          sy_d = neg_q ? -cy_q : cy_q; cyw_d = neg_q ? -cx_q : cx_q;
          ang_d = 1'b1;
          state_d = ypfc_pkg::ST_CORDIC_SETUP;
        end else begin
          sp_d = neg_q ? -cy_q : cy_q; cp_d = neg_q ? -cx_q : cx_q;
          k_d = '0;
          state_d = ypfc_pkg::ST_FRONT;
        end
      end

      // front x, z via multiplier; y directly
      ypfc_pkg::ST_FRONT: begin
        ma = (k_q == 3'd0) ? cyw_q : sy_q; mb = cp_q;
        rnd = 64'(mprod >>> 46) + 64'(mprod[45]);
        if (k_q == 3'd0) begin
          fv_d[0] = ypfc_pkg::clamp_q14(48'(rnd));
          rnd = (64'(sp_q) + 64'sd32768) >>> 16;
          fv_d[1] = ypfc_pkg::clamp_q14(48'(rnd));
          k_d = 3'd1;
        end else begin
          fv_d[2] = ypfc_pkg::clamp_q14(48'(rnd));
          k_d = '0; acc_d = '0;
          state_d = ypfc_pkg::ST_CROSS;
        end
      end

      // cross product: two multiplies per component
      ypfc_pkg::ST_CROSS: begin
        unique case (k_q)
          3'd0: begin ma = 34'(fv_q[1]); mb = 34'(wup_q[2]); end
          3'd1: begin ma = 34'(fv_q[2]); mb = 34'(wup_q[1]); end
          3'd2: begin ma = 34'(fv_q[2]); mb = 34'(wup_q[0]); end
          3'd3: begin ma = 34'(fv_q[0]); mb = 34'(wup_q[2]); end
          3'd4: begin ma = 34'(fv_q[0]); mb = 34'(wup_q[1]); end
          default: begin ma = 34'(fv_q[1]); mb = 34'(wup_q[0]); end
        endcase
        if (!k_q[0]) acc_d = 64'(mprod);
        else cr_d[k_q[2:1]] = 34'(acc_q - 64'(mprod));
        k_d = k_q + 3'd1;
        if (k_q == 3'd5) begin
          k_d = '0; acc_d = '0;
          state_d = ypfc_pkg::ST_LEN;
        end
      end

      ypfc_pkg::ST_LEN: begin
        ma = cr_q[k_q[1:0]]; mb = cr_q[k_q[1:0]];
        acc_d = acc_q + 64'(mprod);
        k_d = k_q + 3'd1;
        if (k_q == 3'd2) begin
          rem_d = 64'(acc_q + 64'(mprod));
          root_d = '0; bit_d = 64'h4000_0000_0000_0000; cnt_d = '0;
          state_d = ypfc_pkg::ST_SQRT;
        end
      end

      // bit-serial floor square root, one result bit a cycle
      ypfc_pkg::ST_SQRT: begin
        trial = root_q + bit_q;
        if (rem_q >= trial) begin
          rem_d = rem_q - trial; root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd31) begin
          k_d = '0; cnt_d = '0;
          if (root_d == '0) begin
            k_d = '0; state_d = ypfc_pkg::ST_UP;
          end else begin
            numer = 64'(cr_q[0]) * 64'sd16384;
            absn = numer < 0 ? -numer : numer;
            rem_d = '0; quo_d = 2 * 64'(absn) + root_d;
            state_d = ypfc_pkg::ST_DIV;
          end
        end
      end

      // restoring divide: q = (2|n| + s) / (2s), one bit per cycle
      ypfc_pkg::ST_DIV: begin
        trial = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
        if (trial >= {root_q[62:0], 1'b0}) begin
          rem_d = trial - {root_q[62:0], 1'b0}; quo_d[0] = 1'b1;
        end else begin
          rem_d = trial;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          rnd = cr_q[k_q[1:0]] < 0 ? -$signed(quo_d) : $signed(quo_d);
          if ($signed(quo_d) < 0 || quo_d > 64'd16384)
            rv_d[k_q[1:0]] = cr_q[k_q[1:0]] < 0 ? -16'sd16384 : 16'sd16384;
          else rv_d[k_q[1:0]] = ypfc_pkg::clamp_q14(48'(rnd));
          cnt_d = '0;
          k_d = k_q + 3'd1;
          if (k_q == 3'd2) begin
            k_d = '0; state_d = ypfc_pkg::ST_UP;
          end else begin
            numer = 64'(cr_q[k_q[1:0] + 2'd1]) * 64'sd16384;
            absn = numer < 0 ? -numer : numer;
            rem_d = '0; quo_d = 2 * 64'(absn) + root_q;
          end
        end
      end

      // up = right x front
      ypfc_pkg::ST_UP: begin
        unique case (k_q)
          3'd0: begin ma = 34'(rv_q[1]); mb = 34'(fv_q[2]); end
          3'd1: begin ma = 34'(rv_q[2]); mb = 34'(fv_q[1]); end
          3'd2: begin ma = 34'(rv_q[2]); mb = 34'(fv_q[0]); end
          3'd3: begin ma = 34'(rv_q[0]); mb = 34'(fv_q[2]); end
          3'd4: begin ma = 34'(rv_q[0]); mb = 34'(fv_q[1]); end
          default: begin ma = 34'(rv_q[1]); mb = 34'(fv_q[0]); end
        endcase
        if (!k_q[0]) acc_d = 64'(mprod);
        else begin
          rnd = (acc_q - 64'(mprod) + 64'sd8192) >>> 14;
          uv_d[k_q[2:1]] = ypfc_pkg::clamp_q14(48'(rnd));
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd5) state_d = ypfc_pkg::ST_DONE;
      end

      ypfc_pkg::ST_DONE: begin
        out_valid_d = 1'b1;
        state_d = ypfc_pkg::ST_IDLE;
      end

      default: state_d = ypfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ypfc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0; fv_q[i] <= '0; rv_q[i] <= '0; uv_q[i] <= '0;
      end
      fv_q[2] <= -16'sd16384;
      rv_q[0] <= 16'sd16384;
      uv_q[1] <= 16'sd16384;
      yaw_q <= -16'sd11520;
      pitch_q <= '0;
      zoom_q <= 13'(ypfc_pkg::ZOOM_MAX);
      k_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      pos_q <= pos_d; fv_q <= fv_d; rv_q <= rv_d; uv_q <= uv_d;
      yaw_q <= yaw_d; pitch_q <= pitch_d; zoom_q <= zoom_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q <= dir_d; ang_q <= ang_d; neg_q <= neg_d;
    it_q <= it_d; cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    sy_q <= sy_d; cyw_q <= cyw_d; sp_q <= sp_d; cp_q <= cp_d;
    acc_q <= acc_d; vel_q <= vel_d; cr_q <= cr_d;
    rem_q <= rem_d; root_q <= root_d; bit_q <= bit_d; cnt_q <= cnt_d; quo_q <= quo_d;
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o = 32'(pos_q[0]);
  assign pos_y_o = 32'(pos_q[1]);
  assign pos_z_o = 32'(pos_q[2]);
  assign front_x_o = fv_q[0];
  assign front_y_o = fv_q[1];
  assign front_z_o = fv_q[2];
  assign up_x_o = uv_q[0];
  assign up_y_o = uv_q[1];
  assign up_z_o = uv_q[2];
  assign zoom_deg_o = zoom_q;
  assign yaw_deg_o = yaw_q;
  assign pitch_deg_o = pitch_q;

`include "yaw_pitch_fly_camera_assert.svh"

  `YPFC_ASSERT(a_busy_stalls, clk_i, rst_ni, (state_q != ypfc_pkg::ST_IDLE) |-> in_stall_o, "input taken while busy")
  `YPFC_ASSERT(a_done_valid, clk_i, rst_ni, (state_q == ypfc_pkg::ST_DONE) |=> out_valid_o, "result not shown after done")
  `YPFC_ASSERT(a_zoom_range, clk_i, rst_ni, (zoom_q >= 13'd128) && (zoom_q <= 13'd5760), "zoom out of range")

endmodule
